// File: rtl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// shared types and constants of the touch press qualifier
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int unsigned SIZE_BITS   = 10;
    localparam int unsigned RAW_BITS    = 12;
    localparam int unsigned TIME_BITS   = 32;
    localparam int unsigned WIN_BITS    = 16;
    localparam int unsigned OUT_BITS    = 10;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic                 RST_PORTRAIT = 1'b0;
    localparam logic [SIZE_BITS-1:0] RST_WIDTH    = 10'd320;
    localparam logic [SIZE_BITS-1:0] RST_HEIGHT   = 10'd240;
    localparam logic [WIN_BITS-1:0]  RST_WINDOW   = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PORTRAIT_MODE = 2'd0,
        REG_SCREEN_WIDTH  = 2'd1,
        REG_SCREEN_HEIGHT = 2'd2,
        REG_SUPPRESS_WIN  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                 portrait;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } t_map_cfg;

endpackage

// File: rtl/touch_press_qualifier_top.sv
// ----------------------------------------------------------------------------
// touch_press_qualifier_top
// stages: input reg, then result reg, from input accept to result accept
// throughput: 1 item per cycle while m_axis_tready does not stall the result stage
// reset: synchronous active low, clears all press state and loads default config
// ----------------------------------------------------------------------------
module touch_press_qualifier_top #(
    parameter int unsigned AGREE_DIVISOR = 20,
    parameter int unsigned COORD_BITS    = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tpq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_x, raw_y, now_ms, wake_takes_press, zero pad
    input  logic [63:0]                       s_axis_tdata,
    // touch_reported
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // point_x, point_y, zero pad
    output logic [23:0]                       m_axis_tdata,
    // is_pressed
    output logic                              m_axis_tuser
);
    import tpq_pkg::*;

    localparam int unsigned CMAX = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int unsigned DW   = CMAX + $clog2(AGREE_DIVISOR + 1);

    // configuration
    t_map_cfg             r_cfg;
    logic [WIN_BITS-1:0]  r_window;

    // input stage
    logic                 r_in_valid;
    logic                 r_in_rep;
    logic [RAW_BITS-1:0]  r_in_rx;
    logic [RAW_BITS-1:0]  r_in_ry;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_in_wake;

    // press state
    logic                  r_sup_active, n_sup_active;
    logic [TIME_BITS-1:0]  r_sup_end,    n_sup_end;
    logic                  r_have_cand,  n_have_cand;
    logic [COORD_BITS-1:0] r_cand_x,     n_cand_x;
    logic [COORD_BITS-1:0] r_cand_y,     n_cand_y;
    logic                  r_press_held, n_press_held;
    logic [COORD_BITS-1:0] r_last_px,    n_last_px;
    logic [COORD_BITS-1:0] r_last_py,    n_last_py;
    logic                  n_pressed;

    // result stage
    logic                  r_out_valid;
    logic                  r_out_pressed;
    logic [OUT_BITS-1:0]   r_out_px;
    logic [OUT_BITS-1:0]   r_out_py;

    logic                  advance;
    logic                  step;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DW-1:0]         dx_scaled;
    logic [DW-1:0]         dy_scaled;
    logic                  agree;
    logic [TIME_BITS-1:0]  t_diff;
    logic                  sup_wait;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    tpq_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_cfg   (r_cfg),
        .i_raw_x (r_in_rx),
        .i_raw_y (r_in_ry),
        .o_sx    (sx),
        .o_sy    (sy)
    );

    // agreement: |d| <= size / N  is the same as  |d| * N <= size
    assign dx        = (sx > r_cand_x) ? sx - r_cand_x : r_cand_x - sx;
    assign dy        = (sy > r_cand_y) ? sy - r_cand_y : r_cand_y - sy;
    assign dx_scaled = DW'(dx) * DW'(AGREE_DIVISOR);
    assign dy_scaled = DW'(dy) * DW'(AGREE_DIVISOR);
    assign agree     = (dx_scaled <= DW'(r_cfg.width)) && (dy_scaled <= DW'(r_cfg.height));

    assign t_diff   = r_in_now - r_sup_end;
    assign sup_wait = r_sup_active && t_diff[TIME_BITS-1];

    always_comb begin
        n_sup_active = r_sup_active;
        n_sup_end    = r_sup_end;
        n_have_cand  = r_have_cand;
        n_cand_x     = r_cand_x;
        n_cand_y     = r_cand_y;
        n_press_held = r_press_held;
        n_last_px    = r_last_px;
        n_last_py    = r_last_py;
        n_pressed    = 1'b0;
        if (sup_wait) begin
            n_have_cand  = 1'b0;
            n_press_held = 1'b0;
        end else begin
            n_sup_active = 1'b0;
            if (!r_in_rep) begin
                n_have_cand  = 1'b0;
                n_press_held = 1'b0;
            end else if (!r_press_held) begin
                if (!r_have_cand || !agree) begin
                    n_have_cand = 1'b1;
                    n_cand_x    = sx;
                    n_cand_y    = sy;
                end else begin
                    n_have_cand = 1'b0;
                    if (r_in_wake) begin
                        n_sup_active = 1'b1;
                        n_sup_end    = r_in_now + TIME_BITS'(r_window);
                    end else begin
                        n_press_held = 1'b1;
                        n_last_px    = sx;
                        n_last_py    = sy;
                        n_pressed    = 1'b1;
                    end
                end
            end else begin
                n_last_px = sx;
                n_last_py = sy;
                n_pressed = 1'b1;
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.portrait <= RST_PORTRAIT;
            r_cfg.width    <= RST_WIDTH;
            r_cfg.height   <= RST_HEIGHT;
            r_window       <= RST_WINDOW;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PORTRAIT_MODE: r_cfg.portrait <= i_cfg_data[0];
                REG_SCREEN_WIDTH:  r_cfg.width    <= i_cfg_data[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: r_cfg.height   <= i_cfg_data[SIZE_BITS-1:0];
                REG_SUPPRESS_WIN:  r_window       <= i_cfg_data[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_rep  <= s_axis_tuser;
            r_in_rx   <= s_axis_tdata[11:0];
            r_in_ry   <= s_axis_tdata[23:12];
            r_in_now  <= s_axis_tdata[55:24];
            r_in_wake <= s_axis_tdata[56];
        end
    end

    // press state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sup_active <= 1'b0;
            r_sup_end    <= '0;
            r_have_cand  <= 1'b0;
            r_cand_x     <= '0;
            r_cand_y     <= '0;
            r_press_held <= 1'b0;
            r_last_px    <= '0;
            r_last_py    <= '0;
        end else if (step) begin
            r_sup_active <= n_sup_active;
            r_sup_end    <= n_sup_end;
            r_have_cand  <= n_have_cand;
            r_cand_x     <= n_cand_x;
            r_cand_y     <= n_cand_y;
            r_press_held <= n_press_held;
            r_last_px    <= n_last_px;
            r_last_py    <= n_last_py;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_out_pressed <= n_pressed;
            r_out_px      <= OUT_BITS'(n_last_px);
            r_out_py      <= OUT_BITS'(n_last_py);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_pressed;
    assign m_axis_tdata  = {4'd0, r_out_py, r_out_px};

`ifndef SYNTH
    a_no_point_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !r_in_rep) |=> (m_axis_tvalid && !m_axis_tuser))
        else $error("released expected for an item with no point");

    a_cand_held_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_have_cand && r_press_held))
        else $error("candidate and held press both set");

    a_press_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && n_pressed) |=> (r_press_held && !r_sup_active))
        else $error("pressed result without held press");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");
`endif

endmodule

// File: rtl/tpq_map.sv
// ----------------------------------------------------------------------------
// tpq_map
// raw controller point to screen point: orientation swap and clamp
// ----------------------------------------------------------------------------
module tpq_map #(
    parameter int unsigned COORD_BITS = 10
) (
    input  tpq_pkg::t_map_cfg              i_cfg,
    input  logic [tpq_pkg::RAW_BITS-1:0]   i_raw_x,
    input  logic [tpq_pkg::RAW_BITS-1:0]   i_raw_y,
    output logic [COORD_BITS-1:0]          o_sx,
    output logic [COORD_BITS-1:0]          o_sy
);
    import tpq_pkg::*;

    logic [SIZE_BITS-1:0] lim_w;
    logic [SIZE_BITS-1:0] lim_h;
    logic [RAW_BITS-1:0]  lim_w_ext;
    logic [RAW_BITS-1:0]  lim_h_ext;
    logic [RAW_BITS-1:0]  h_ext;
    logic [RAW_BITS-1:0]  src_x;
    logic [RAW_BITS-1:0]  clamp_x;
    logic [RAW_BITS-1:0]  clamp_y;

    assign lim_w     = (i_cfg.width == '0) ? '0 : i_cfg.width - 1'b1;
    assign lim_h     = (i_cfg.height == '0) ? '0 : i_cfg.height - 1'b1;
    assign lim_w_ext = RAW_BITS'(lim_w);
    assign lim_h_ext = RAW_BITS'(lim_h);
    assign h_ext     = RAW_BITS'(i_cfg.height);

    assign src_x   = i_cfg.portrait ? i_raw_x : i_raw_y;
    assign clamp_x = (src_x > lim_w_ext) ? lim_w_ext : src_x;

    always_comb begin
        if (i_cfg.portrait) begin
            clamp_y = (i_raw_y > lim_h_ext) ? lim_h_ext : i_raw_y;
        end else begin
            // reversed raw x, negative values pinned to zero
            clamp_y = (i_raw_x >= h_ext) ? '0 : h_ext - 1'b1 - i_raw_x;
        end
    end

    assign o_sx = COORD_BITS'(clamp_x);
    assign o_sy = COORD_BITS'(clamp_y);

endmodule
